>>> rtl/mme_pkg.sv
// Package for the matrix multiply engine: widths, register codes, control word
// and status types, and the microcode program of the sequencer.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mme_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 3;
  localparam int IDX_REACH     = 1 << IDX_W;
  localparam int DIM_W         = 4;
  localparam int GUARD_W       = 4;
  localparam int ACC_W         = 2 * DATA_W + GUARD_W;
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_SEL_W  = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Register selects, taken from paddr[3:2].
  localparam logic [REG_SEL_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_COLS_B     = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

  typedef enum logic [2:0] {
    STEP_IDLE   = 3'd0,
    STEP_CELL   = 3'd1,
    STEP_MAC    = 3'd2,
    STEP_DRAIN1 = 3'd3,
    STEP_DRAIN2 = 3'd4,
    STEP_EMIT   = 3'd5,
    STEP_NEXT   = 3'd6,
    STEP_DONE   = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    JC_NONE       = 3'd0,
    JC_ALWAYS     = 3'd1,
    JC_NO_START   = 3'd2,
    JC_K_MORE     = 3'd3,
    JC_OUT_BUSY   = 3'd4,
    JC_MORE_CELLS = 3'd5
  } jump_cond_e;

  typedef struct packed {
    logic       in_rdy;
    logic       clr_pos;
    logic       clr_acc;
    logic       issue;
    logic       emit;
    logic       adv;
    jump_cond_e cond;
    step_e      target;
  } ucode_t;

  typedef struct packed {
    logic start_fire;
    logic k_more;
    logic out_busy;
    logic more_cells;
  } status_t;

  localparam ucode_t UC_NOP = '{
    in_rdy: 1'b0, clr_pos: 1'b0, clr_acc: 1'b0, issue: 1'b0,
    emit: 1'b0, adv: 1'b0, cond: JC_NONE, target: STEP_IDLE
  };

  // The control program: one word per step.
  function automatic ucode_t ucode_fetch(step_e step);
    ucode_t w;
    w = UC_NOP;
    unique case (step)
      STEP_IDLE: begin
        w.in_rdy  = 1'b1;
        w.clr_pos = 1'b1;
        w.cond    = JC_NO_START;
        w.target  = STEP_IDLE;
      end
      STEP_CELL: begin
        w.clr_acc = 1'b1;
      end
      STEP_MAC: begin
        w.issue  = 1'b1;
        w.cond   = JC_K_MORE;
        w.target = STEP_MAC;
      end
      STEP_DRAIN1: begin
        w.cond = JC_NONE;
      end
      STEP_DRAIN2: begin
        w.cond = JC_NONE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JC_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_NEXT: begin
        w.adv    = 1'b1;
        w.cond   = JC_MORE_CELLS;
        w.target = STEP_CELL;
      end
      STEP_DONE: begin
        w.cond   = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/mme_if.sv
// Stream interfaces of the matrix multiply engine: element loads in,
// product elements out, each with valid/ready.
// Depends on mme_pkg for the field widths.
`timescale 1ns / 1ps

interface mme_load_if
  import mme_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     which_matrix;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;
  logic                     start_req;

  modport source (
    output valid, which_matrix, row_index, col_index, element_value, start_req,
    input  ready
  );
  modport sink (
    input  valid, which_matrix, row_index, col_index, element_value, start_req,
    output ready
  );
endinterface

interface mme_result_if
  import mme_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] product_value;
  logic                     last;

  modport source (
    output valid, out_row, out_col, product_value, last,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, product_value, last,
    output ready
  );
endinterface

>>> rtl/mme_cfg_regs.sv
// APB-style register bank holding the three matrix dimensions.
// Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_cfg_regs
  import mme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output dims_t                 dims_o
);

  dims_t                dims_q, dims_d;
  logic                 wr_en;
  logic [REG_SEL_W-1:0] sel;
  logic [DIM_W-1:0]     rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    dims_d = dims_q;
    if (wr_en) begin
      unique case (sel)
        REG_ROWS_A:     dims_d.rows_a     = pwdata[DIM_W-1:0];
        REG_INNER_SIZE: dims_d.inner_size = pwdata[DIM_W-1:0];
        REG_COLS_B:     dims_d.cols_b     = pwdata[DIM_W-1:0];
        default:        dims_d = dims_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= '{rows_a: DIM_RESET, inner_size: DIM_RESET, cols_b: DIM_RESET};
    end else begin
      dims_q <= dims_d;
    end
  end

  always_comb begin
    unique case (sel)
      REG_ROWS_A:     rd_val = dims_q.rows_a;
      REG_INNER_SIZE: rd_val = dims_q.inner_size;
      REG_COLS_B:     rd_val = dims_q.cols_b;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = CFG_DATA_W'(rd_val);
  assign dims_o = dims_q;

endmodule

>>> rtl/mme_ucode_seq.sv
// Microcode sequencer: step counter, control-word fetch from the program in
// mme_pkg, and conditional jumps on datapath status. Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_ucode_seq
  import mme_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ucode_t  ctrl_o
);

  step_e  step_q, step_d;
  ucode_t word;
  logic   take;

  always_comb begin
    word = ucode_fetch(step_q);
  end

  always_comb begin
    unique case (word.cond)
      JC_NONE:       take = 1'b0;
      JC_ALWAYS:     take = 1'b1;
      JC_NO_START:   take = !status_i.start_fire;
      JC_K_MORE:     take = status_i.k_more;
      JC_OUT_BUSY:   take = status_i.out_busy;
      JC_MORE_CELLS: take = status_i.more_cells;
      default:       take = 1'b0;
    endcase
    step_d = take ? word.target : step_e'(step_q + 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

endmodule

>>> rtl/mme_datapath.sv
// Datapath of the matrix multiply engine: the A and B element memories,
// row/column/term counters, registered multiplier, wide accumulator,
// scaling with saturation, and the output register. Depends on mme_pkg
// and the stream interfaces in mme_if.
`timescale 1ns / 1ps

module mme_datapath
  import mme_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucode_t              ctrl_i,
  input  dims_t               dims_i,
  output status_t             status_o,
  mme_load_if.sink            load,
  mme_result_if.source        result
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_CAP = (MAX_DIM < IDX_REACH) ? MAX_DIM : IDX_REACH;

  // Last index in use for one dimension: zero acts as one, large values clip.
  function automatic logic [IDX_W-1:0] last_idx(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] m1;
    m1 = v - DIM_W'(1);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > DIM_CAP) begin
      return IDX_W'(DIM_CAP - 1);
    end else begin
      return m1[IDX_W-1:0];
    end
  endfunction

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  logic [IDX_W-1:0] m_last, n_last, p_last;
  logic [IDX_W-1:0] r_q, c_q, k_q;
  logic [IDX_W-1:0] r_d, c_d, k_d;

  logic              load_fire, in_range;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;

  logic signed [DATA_W-1:0]   a_rd_q, b_rd_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q, shifted;
  logic                       rd_v_q, mul_v_q;

  logic                  in_sat_range, is_last_cell, out_busy, out_load;
  logic [DATA_W-1:0]     sat_val;
  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_row_q, out_col_q;
  logic [DATA_W-1:0]     out_val_q;
  logic                  out_last_q;

  assign m_last = last_idx(dims_i.rows_a);
  assign n_last = last_idx(dims_i.inner_size);
  assign p_last = last_idx(dims_i.cols_b);

  // Element loads.
  assign load.ready = ctrl_i.in_rdy;
  assign load_fire  = load.valid & ctrl_i.in_rdy;
  assign in_range   = (32'(load.row_index) < MAX_DIM) && (32'(load.col_index) < MAX_DIM);
  assign wr_addr    = ADDR_W'(load.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(load.col_index);

  always_ff @(posedge clk_i) begin
    if (load_fire && in_range && !load.which_matrix) begin
      a_mem[wr_addr] <= load.element_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire && in_range && load.which_matrix) begin
      b_mem[wr_addr] <= load.element_value;
    end
  end

  // Term reads: A[r][k] and B[k][c].
  assign a_raddr = ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign b_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      a_rd_q <= a_mem[a_raddr];
      b_rd_q <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_acc) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Counters.
  assign is_last_cell = (r_q == m_last) && (c_q == p_last);

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    if (ctrl_i.clr_pos) begin
      r_d = '0;
      c_d = '0;
    end else if (ctrl_i.adv) begin
      if (c_q == p_last) begin
        c_d = '0;
        r_d = r_q + IDX_W'(1);
      end else begin
        c_d = c_q + IDX_W'(1);
      end
    end
    if (ctrl_i.clr_acc) begin
      k_d = '0;
    end else if (ctrl_i.issue) begin
      k_d = k_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      rd_v_q  <= ctrl_i.issue;
      mul_v_q <= rd_v_q;
    end
  end

  // Scale back to the element format; the sum fits when every bit above
  // the result's sign bit matches it.
  assign shifted      = acc_q >>> FRAC_BITS;
  assign in_sat_range = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
  assign sat_val      = in_sat_range ? shifted[DATA_W-1:0] :
                        (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

  // Output register; it reloads in the cycle its current result is taken.
  assign out_busy = out_valid_q && !result.ready;
  assign out_load = ctrl_i.emit && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= r_q;
      out_col_q  <= c_q;
      out_val_q  <= sat_val;
      out_last_q <= is_last_cell;
    end
  end

  assign result.valid         = out_valid_q;
  assign result.out_row       = out_row_q;
  assign result.out_col       = out_col_q;
  assign result.product_value = out_val_q;
  assign result.last          = out_last_q;

  assign status_o.start_fire = load_fire & load.start_req;
  assign status_o.k_more     = (k_q != n_last);
  assign status_o.out_busy   = out_busy;
  assign status_o.more_cells = !is_last_cell;

endmodule

>>> rtl/matrix_multiply_engine.sv
// Matrix multiply engine: loads A and B element by element and streams C = A * B.
// Uses mme_pkg, mme_if, mme_cfg_regs, mme_ucode_seq and mme_datapath.
`timescale 1ns / 1ps

// Elements of A and B are loaded one per cycle while the block waits for a
// start, each tagged with its row and column, into two element memories that
// are undefined until written (no clearing pass follows reset). A load with
// start_req set is stored first; then the block computes C = A * B and sends
// every element of C in row-major order, the final one marked with last. For
// each element of C the block clears the accumulator, does one memory read per
// term, drains the read and multiplier registers, loads the output register
// and steps to the next element; after the last one it passes a done step and
// returns to accepting loads. The single 32x32 multiplier and the one read
// port per memory set this pace, and a stalled output holds the block in its
// emit step. Products are summed exactly, scaled back by FRAC_BITS with
// rounding toward minus infinity, and saturated to 32 bits. Dimension
// registers read as zero act as one, and values above the cap act as the cap.
// Write the dimension registers only while no product is being computed.

module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mme_load_if.sink              load_i,
  mme_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  dims_t   dims;
  ucode_t  ctrl;
  status_t status;

  mme_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  mme_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mme_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .dims_i   (dims),
    .status_o (status),
    .load     (load_i),
    .result   (result_o)
  );

  // A start transfer moves the sequencer out of its load step.
  a_start_leaves_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    status.start_fire |=> !load_i.ready
  ) else $error("loads still accepted after a start transfer");

  // An emit step with a free output register presents a result next cycle.
  a_emit_shows_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && !status.out_busy) |=> result_o.valid
  ) else $error("emitted product element not presented");

  // After the final element, the block returns to taking loads.
  a_done_returns: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl.adv && !status.more_cells) |=> ##1 load_i.ready
  ) else $error("sequencer did not return to loading after the last element");

  // Clearing the accumulator for a cell is followed by its first term read.
  a_issue_after_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctrl.clr_acc |=> ctrl.issue
  ) else $error("first term read does not follow the accumulator clear");

endmodule

>>> tb/sv/tb_matrix_multiply_engine.sv
// Self-checking testbench for matrix_multiply_engine: loads A and B, starts products
// and checks every element of C against an in-bench Q16.16 product predictor.
// Depends on mme_pkg, the mme_load_if and mme_result_if interfaces, and the RTL.
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int  MAX_DIM      = MAX_DIM_DEF;
  localparam int  FRAC_BITS    = FRAC_BITS_DEF;
  localparam int  DIM_CAP      = (MAX_DIM < IDX_REACH) ? MAX_DIM : IDX_REACH;
  localparam int  STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int  RAND_ITEMS   = 220;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  LIMIT_NS     = 8_000_000;
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;
  localparam logic signed [71:0] Q_MAX = 72'sh0_7FFF_FFFF;
  localparam logic signed [71:0] Q_MIN = -72'sh0_8000_0000;

  typedef struct packed {
    logic              which;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              start;
  } elem_load_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              last;
  } product_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mme_load_if   load_bus ();
  mme_result_if result_bus ();

  matrix_multiply_engine uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: element stores, which entries hold data, and the dimensions.
  logic [DATA_W-1:0] a_elems [STORE_DEPTH];
  logic [DATA_W-1:0] b_elems [STORE_DEPTH];
  bit                a_loaded [STORE_DEPTH];
  bit                b_loaded [STORE_DEPTH];
  dims_t             dims;
  product_t          product_q [$];
  int                errors;
  bit                in_burst;
  bit                out_burst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  function automatic int span(logic [DIM_W-1:0] code);
    if (code == '0) return 1;
    if (int'(code) > DIM_CAP) return DIM_CAP;
    return int'(code);
  endfunction

  function automatic logic [DATA_W-1:0] dot_q16(int r, int c, int n);
    logic signed [71:0] acc;
    logic signed [71:0] ext;
    logic signed [71:0] scaled;
    longint             term;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      term = longint'($signed(a_elems[r * MAX_DIM + k])) *
             longint'($signed(b_elems[k * MAX_DIM + c]));
      ext = term;
      acc = acc + ext;
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > Q_MAX) return SAT_MAX;
    if (scaled < Q_MIN) return SAT_MIN;
    return scaled[DATA_W-1:0];
  endfunction

  // Store an accepted element and, on a start, queue every element of C.
  // A load outside the stores is dropped, but its start still counts.
  task automatic accept_load(input elem_load_t it);
    int       idx;
    int       m;
    int       n;
    int       p;
    product_t want;
    idx = int'(it.row) * MAX_DIM + int'(it.col);
    if (int'(it.row) < MAX_DIM && int'(it.col) < MAX_DIM) begin
      if (it.which == SEL_A) begin
        a_elems[idx]  = it.value;
        a_loaded[idx] = 1'b1;
      end else begin
        b_elems[idx]  = it.value;
        b_loaded[idx] = 1'b1;
      end
    end
    if (it.start) begin
      m = span(dims.rows_a);
      n = span(dims.inner_size);
      p = span(dims.cols_b);
      for (int r = 0; r < m; r++) begin
        for (int c = 0; c < p; c++) begin
          want.row   = IDX_W'(r);
          want.col   = IDX_W'(c);
          want.value = dot_q16(r, c, n);
          want.last  = (r == m - 1) && (c == p - 1);
          product_q.push_back(want);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    product_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (product_q.size() == 0) begin
        report_mismatch("unexpected product value", '0, result_bus.product_value);
      end else begin
        want = product_q.pop_front();
        if (result_bus.out_row !== want.row)
          report_mismatch("out_row", 32'(want.row), 32'(result_bus.out_row));
        if (result_bus.out_col !== want.col)
          report_mismatch("out_col", 32'(want.col), 32'(result_bus.out_col));
        if (result_bus.product_value !== want.value)
          report_mismatch("product_value", want.value, result_bus.product_value);
        if (result_bus.last !== want.last)
          report_mismatch("last", 32'(want.last), 32'(result_bus.last));
      end
    end
  end

  // Receiver: a random stall before each product transfer, none in burst phases.
  initial begin
    int stall;
    result_bus.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_bus.valid) @(posedge clk_i);
    end
  end

  task automatic send_load(input elem_load_t it);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      load_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    load_bus.valid         <= 1'b1;
    load_bus.which_matrix  <= it.which;
    load_bus.row_index     <= it.row;
    load_bus.col_index     <= it.col;
    load_bus.element_value <= it.value;
    load_bus.start_req     <= it.start;
    @(posedge clk_i);
    while (!load_bus.ready) @(posedge clk_i);
    accept_load(it);
  endtask

  // Stop sending, let every queued product arrive, then let the sequencer settle.
  task automatic wait_idle();
    load_bus.valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dim(input logic [REG_SEL_W-1:0] sel, input logic [DIM_W-1:0] code);
    logic [CFG_DATA_W-1:0] upper;
    upper = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {upper[CFG_DATA_W-1:DIM_W], code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (sel)
      REG_ROWS_A:     dims.rows_a = code;
      REG_INNER_SIZE: dims.inner_size = code;
      REG_COLS_B:     dims.cols_b = code;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic read_dim(input logic [REG_SEL_W-1:0] sel, output logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] elem_value();
    case ($urandom_range(0, 7))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3:    return DATA_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic elem_load_t mk_load(logic which, int row, int col,
                                         logic [DATA_W-1:0] value, logic start);
    elem_load_t it;
    it.which = which;
    it.row   = IDX_W'(row);
    it.col   = IDX_W'(col);
    it.value = value;
    it.start = start;
    return it;
  endfunction

  function automatic elem_load_t noise_load();
    return mk_load($urandom_range(0, 1) ? SEL_B : SEL_A, $urandom_range(0, IDX_REACH - 1),
                   $urandom_range(0, IDX_REACH - 1), elem_value(), 1'b0);
  endfunction

  task automatic test_reset_dims();
    logic [CFG_DATA_W-1:0] data;
    read_dim(REG_ROWS_A, data);
    if (data[DIM_W-1:0] !== DIM_RESET) report_mismatch("rows_a after reset", 32'(DIM_RESET), data);
    read_dim(REG_INNER_SIZE, data);
    if (data[DIM_W-1:0] !== DIM_RESET)
      report_mismatch("inner_size after reset", 32'(DIM_RESET), data);
    read_dim(REG_COLS_B, data);
    if (data[DIM_W-1:0] !== DIM_RESET) report_mismatch("cols_b after reset", 32'(DIM_RESET), data);
  endtask

  // One-by-one products: saturation both ways, the largest product, flooring of
  // a negative sum and zero.
  task automatic test_saturation();
    wait_idle();
    write_dim(REG_ROWS_A, 4'd1);
    write_dim(REG_INNER_SIZE, 4'd1);
    write_dim(REG_COLS_B, 4'd1);
    send_load(mk_load(SEL_A, 0, 0, SAT_MAX, 1'b0));
    send_load(mk_load(SEL_B, 0, 0, SAT_MAX, 1'b1));
    send_load(mk_load(SEL_A, 0, 0, SAT_MIN, 1'b1));
    send_load(mk_load(SEL_B, 0, 0, SAT_MIN, 1'b1));
    send_load(mk_load(SEL_A, 0, 0, 32'hFFFF_FFFF, 1'b1));
    send_load(mk_load(SEL_B, 0, 0, 32'h0000_0001, 1'b1));
    send_load(mk_load(SEL_A, 0, 0, 32'h0000_0000, 1'b1));
  endtask

  // A zero dimension acts as one and codes above the cap act as eight: 8x1x8.
  task automatic test_dim_clamp();
    wait_idle();
    write_dim(REG_ROWS_A, 4'd15);
    write_dim(REG_INNER_SIZE, 4'd0);
    write_dim(REG_COLS_B, 4'd9);
    for (int r = 1; r < DIM_CAP; r++) send_load(mk_load(SEL_A, r, 0, elem_value(), 1'b0));
    for (int c = 1; c < DIM_CAP; c++)
      send_load(mk_load(SEL_B, 0, c, elem_value(), c == DIM_CAP - 1));
  endtask

  // Phases of random dimensions; each runs a few load sequences that end in a start.
  // Most sequences reload all of A and B, some only what is missing or that and a
  // random part of the rest, mixed with stray loads anywhere in the stores.
  task automatic test_random_mixes();
    elem_load_t       seq [$];
    elem_load_t       tmp;
    logic [DIM_W-1:0] codes [3];
    int               m;
    int               n;
    int               p;
    int               kind;
    int               wide;
    int               pick;
    int               sent;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      wide = $urandom_range(0, 5);
      for (int d = 0; d < 3; d++) begin
        if (d == wide)
          codes[d] = $urandom_range(0, 1) ? 4'd8 : DIM_W'($urandom_range(9, 15));
        else
          codes[d] = DIM_W'($urandom_range(0, 4));
      end
      wait_idle();
      write_dim(REG_ROWS_A, codes[0]);
      write_dim(REG_INNER_SIZE, codes[1]);
      write_dim(REG_COLS_B, codes[2]);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      m = span(codes[0]);
      n = span(codes[1]);
      p = span(codes[2]);
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        seq.delete();
        for (int r = 0; r < m; r++)
          for (int k = 0; k < n; k++)
            if (kind < 7 || !a_loaded[r * MAX_DIM + k] || (kind < 9 && $urandom_range(0, 1)))
              seq.push_back(mk_load(SEL_A, r, k, elem_value(), 1'b0));
        for (int k = 0; k < n; k++)
          for (int c = 0; c < p; c++)
            if (kind < 7 || !b_loaded[k * MAX_DIM + c] || (kind < 9 && $urandom_range(0, 1)))
              seq.push_back(mk_load(SEL_B, k, c, elem_value(), 1'b0));
        for (int j = seq.size() - 1; j > 0; j--) begin
          pick      = $urandom_range(0, j);
          tmp       = seq[j];
          seq[j]    = seq[pick];
          seq[pick] = tmp;
        end
        // With everything already loaded, a stray load may carry the start.
        if (seq.size() == 0) seq.push_back(noise_load());
        seq[seq.size() - 1].start = 1'b1;
        foreach (seq[j]) begin
          if ($urandom_range(0, 3) == 0) begin
            send_load(noise_load());
            sent++;
          end
          send_load(seq[j]);
          sent++;
        end
        if ($urandom_range(0, 4) == 0) wait_idle();
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin
    errors                 = 0;
    in_burst               = 1'b0;
    out_burst              = 1'b0;
    dims                   = {DIM_RESET, DIM_RESET, DIM_RESET};
    load_bus.valid         = 1'b0;
    load_bus.which_matrix  = SEL_A;
    load_bus.row_index     = '0;
    load_bus.col_index     = '0;
    load_bus.element_value = '0;
    load_bus.start_req     = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    rst_ni                 = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_dims();
    test_saturation();
    test_dim_clamp();
    test_random_mixes();
    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
